@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the instruction step core.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent in the same cycle.
`define ASSERT_IMPL(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Consequent in the next cycle.
`define ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

@@ src/cis_pkg.sv @@
// Package of the instruction step core: store size, command and ALU codes,
// reset values and the ALU request and response types. No dependencies.
package cis_pkg;

	localparam int MEM_DEPTH = 65536;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [15:0] MARK_ADDR = 16'hFF44;
	localparam logic [7:0]  MARK_BYTE = 8'h90;

	localparam logic [7:0]  RST_A  = 8'h01;
	localparam logic [7:0]  RST_B  = 8'h00;
	localparam logic [7:0]  RST_C  = 8'h13;
	localparam logic [7:0]  RST_D  = 8'h00;
	localparam logic [7:0]  RST_E  = 8'hD8;
	localparam logic [7:0]  RST_H  = 8'h01;
	localparam logic [7:0]  RST_L  = 8'h4D;
	localparam logic [3:0]  RST_F  = 4'b1011;
	localparam logic [15:0] RST_SP = 16'hFFFE;
	localparam logic [15:0] RST_PC = 16'h0100;

	// flag nibble bit positions
	localparam int FZ = 3;
	localparam int FN = 2;
	localparam int FH = 1;
	localparam int FC = 0;

	localparam logic [3:0] ALU_ADDW  = 4'd0;
	localparam logic [3:0] ALU_ADD8  = 4'd1;
	localparam logic [3:0] ALU_SUB8  = 4'd2;
	localparam logic [3:0] ALU_INC8  = 4'd3;
	localparam logic [3:0] ALU_DEC8  = 4'd4;
	localparam logic [3:0] ALU_AND   = 4'd5;
	localparam logic [3:0] ALU_XOR   = 4'd6;
	localparam logic [3:0] ALU_OR    = 4'd7;
	localparam logic [3:0] ALU_RR    = 4'd8;
	localparam logic [3:0] ALU_SRL   = 4'd9;
	localparam logic [3:0] ALU_DAA   = 4'd10;
	localparam logic [3:0] ALU_ADDHL = 4'd11;
	localparam logic [3:0] ALU_SPE   = 4'd12;

	typedef struct packed {
		logic [3:0]  op;
		logic [15:0] a;
		logic [15:0] b;
		logic        cin;
		logic [3:0]  fin;
	} alu_req_t;

	typedef struct packed {
		logic [15:0] res;
		logic [3:0]  f;
	} alu_rsp_t;

endpackage

@@ src/cis_ram.sv @@
// Single-port byte store with registered read data.
// Generic; no package dependency.
module cis_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

@@ src/cis_alu.sv @@
// Shared 8/16-bit arithmetic, logic, shift and decimal-adjust unit.
// Uses cis_pkg for op codes, flag positions and the request types.
module cis_alu
	import cis_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [8:0]  s9;
	logic [4:0]  h5;
	logic [16:0] s17;
	logic [12:0] h13;
	logic [7:0]  r8;
	logic [7:0]  adj;
	logic        dc;

	always_comb begin
		s9  = 9'd0;
		h5  = 5'd0;
		s17 = 17'd0;
		h13 = 13'd0;
		r8  = 8'd0;
		adj = 8'd0;
		dc  = req.fin[FC];
		rsp.res = 16'd0;
		rsp.f   = req.fin;
		case (req.op)
			ALU_ADDW: begin
				rsp.res = req.a + req.b;
			end
			ALU_ADD8: begin
				s9 = {1'b0, req.a[7:0]} + {1'b0, req.b[7:0]} + {8'd0, req.cin};
				h5 = {1'b0, req.a[3:0]} + {1'b0, req.b[3:0]} + {4'd0, req.cin};
				rsp.res = {8'd0, s9[7:0]};
				rsp.f = {s9[7:0] == 8'd0, 1'b0, h5[4], s9[8]};
			end
			ALU_SUB8: begin
				rsp.res = {8'd0, req.a[7:0] - req.b[7:0]};
				rsp.f = {req.a[7:0] == req.b[7:0], 1'b1, req.a[3:0] < req.b[3:0],
					req.a[7:0] < req.b[7:0]};
			end
			ALU_INC8: begin
				r8 = req.a[7:0] + 8'd1;
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 1'b0, req.a[3:0] == 4'hF, req.fin[FC]};
			end
			ALU_DEC8: begin
				r8 = req.a[7:0] - 8'd1;
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 1'b1, req.a[3:0] == 4'h0, req.fin[FC]};
			end
			ALU_AND: begin
				r8 = req.a[7:0] & req.b[7:0];
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
			end
			ALU_XOR: begin
				r8 = req.a[7:0] ^ req.b[7:0];
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 3'b000};
			end
			ALU_OR: begin
				r8 = req.a[7:0] | req.b[7:0];
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 3'b000};
			end
			ALU_RR: begin
				r8 = {req.fin[FC], req.a[7:1]};
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 2'b00, req.a[0]};
			end
			ALU_SRL: begin
				r8 = {1'b0, req.a[7:1]};
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, 2'b00, req.a[0]};
			end
			ALU_DAA: begin
				if (req.fin[FN]) begin
					adj = (req.fin[FH] ? 8'h06 : 8'h00) + (req.fin[FC] ? 8'h60 : 8'h00);
					r8 = req.a[7:0] - adj;
				end else begin
					if (req.fin[FH] || req.a[3:0] > 4'h9) begin
						adj = 8'h06;
					end
					if (req.fin[FC] || req.a[7:0] > 8'h99) begin
						adj = adj + 8'h60;
						dc = 1'b1;
					end
					r8 = req.a[7:0] + adj;
				end
				rsp.res = {8'd0, r8};
				rsp.f = {r8 == 8'd0, req.fin[FN], 1'b0, dc};
			end
			ALU_ADDHL: begin
				s17 = {1'b0, req.a} + {1'b0, req.b};
				h13 = {1'b0, req.a[11:0]} + {1'b0, req.b[11:0]};
				rsp.res = s17[15:0];
				rsp.f = {req.fin[FZ], 1'b0, h13[12], s17[16]};
			end
			ALU_SPE: begin
				h5 = {1'b0, req.a[3:0]} + {1'b0, req.b[3:0]};
				s9 = {1'b0, req.a[7:0]} + {1'b0, req.b[7:0]};
				rsp.res = req.a + {{8{req.b[7]}}, req.b[7:0]};
				rsp.f = {2'b00, h5[4], s9[8]};
			end
			default: begin
				rsp.res = 16'd0;
			end
		endcase
	end

endmodule

@@ src/cpu_instruction_step_core.sv @@
// Top level of the instruction step core: sequencer, register file and
// result register. Uses cis_pkg, cis_ram, cis_alu and assert_macros.svh.
//
// One word in gives one word out. After reset the store is cleared in a pass
// over all MEM_DEPTH (65536) addresses, one byte a cycle, before the first
// word is taken; address MARK_ADDR gets MARK_BYTE instead of zero. A step
// passes every opcode, operand, data byte and stack byte through the single
// store port one per cycle, and the shared ALU does the work in the execute
// state. A finished result waits in the output register while the next word
// is taken.
module cpu_instruction_step_core
	import cis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] address,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  reg_a,
	output logic [7:0]  flag_byte,
	output logic [7:0]  reg_b,
	output logic [7:0]  reg_c,
	output logic [7:0]  reg_d,
	output logic [7:0]  reg_e,
	output logic [7:0]  reg_h,
	output logic [7:0]  reg_l,
	output logic [15:0] stack_ptr,
	output logic [15:0] prog_counter,
	output logic        fault,
	output logic [7:0]  read_byte
);

	`include "assert_macros.svh"

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_RDW  = 4'd2;
	localparam logic [3:0] S_OP   = 4'd3;
	localparam logic [3:0] S_IMM1 = 4'd4;
	localparam logic [3:0] S_IMM2 = 4'd5;
	localparam logic [3:0] S_MEM  = 4'd6;
	localparam logic [3:0] S_RD1  = 4'd7;
	localparam logic [3:0] S_RD2  = 4'd8;
	localparam logic [3:0] S_EXE  = 4'd9;
	localparam logic [3:0] S_WR2  = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	localparam logic [2:0] RK_NONE = 3'd0;
	localparam logic [2:0] RK_HL   = 3'd1;
	localparam logic [2:0] RK_DE   = 3'd2;
	localparam logic [2:0] RK_HIGH = 3'd3;
	localparam logic [2:0] RK_ABS  = 3'd4;
	localparam logic [2:0] RK_POP  = 3'd5;

	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

	function automatic logic op_known(input logic [7:0] op);
		case (op)
			8'h00, 8'hF3, 8'hFB, 8'h01, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08, 8'h0B,
			8'h0C, 8'h0D, 8'h0E, 8'h11, 8'h12, 8'h13, 8'h14, 8'h18, 8'h1A, 8'h1B,
			8'h1C, 8'h1D, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26,
			8'h27, 8'h28, 8'h29, 8'h2A, 8'h2C, 8'h2D, 8'h2E, 8'h30, 8'h31, 8'h32,
			8'h33, 8'h35, 8'h38, 8'h39, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h44, 8'h46,
			8'h47, 8'h4E, 8'h4F, 8'h56, 8'h57, 8'h5D, 8'h5E, 8'h5F, 8'h62, 8'h66,
			8'h67, 8'h6B, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h77, 8'h78,
			8'h79, 8'h7A, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'hA7, 8'hA9, 8'hAD, 8'hAE,
			8'hAF, 8'hB0, 8'hB1, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hC1,
			8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC8, 8'hC9, 8'hCB, 8'hCD, 8'hCE,
			8'hD0, 8'hD1, 8'hD5, 8'hD6, 8'hE0, 8'hE1, 8'hE5, 8'hE6, 8'hE8, 8'hE9,
			8'hEA, 8'hEE, 8'hF0, 8'hF1, 8'hF5, 8'hF8, 8'hF9, 8'hFA, 8'hFE: op_known = 1'b1;
			default: op_known = 1'b0;
		endcase
	endfunction

	function automatic logic [1:0] op_len(input logic [7:0] op);
		case (op)
			8'h06, 8'h0E, 8'h18, 8'h20, 8'h26, 8'h28, 8'h2E, 8'h30, 8'h38, 8'h3E,
			8'hC6, 8'hCB, 8'hCE, 8'hD6, 8'hE0, 8'hE6, 8'hE8, 8'hEE, 8'hF0, 8'hF8,
			8'hFE: op_len = 2'd1;
			8'h01, 8'h08, 8'h11, 8'h21, 8'h31, 8'hC2, 8'hC3, 8'hC4, 8'hCD, 8'hEA,
			8'hFA: op_len = 2'd2;
			default: op_len = 2'd0;
		endcase
	endfunction

	function automatic logic [2:0] rd_kind(input logic [7:0] op);
		case (op)
			8'h2A, 8'h35, 8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h7E, 8'hAE,
			8'hB6: rd_kind = RK_HL;
			8'h1A: rd_kind = RK_DE;
			8'hF0: rd_kind = RK_HIGH;
			8'hFA: rd_kind = RK_ABS;
			8'hC1, 8'hC8, 8'hC9, 8'hD0, 8'hD1, 8'hE1, 8'hF1: rd_kind = RK_POP;
			default: rd_kind = RK_NONE;
		endcase
	endfunction

	function automatic logic cb_known(input logic [7:0] op);
		case (op)
			8'h38, 8'h19, 8'h1A, 8'h1B: cb_known = 1'b1;
			default: cb_known = 1'b0;
		endcase
	endfunction

	logic [3:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [7:0]        a_q, b_q, c_q, d_q, e_q, h_q, l_q;
	logic [3:0]        f_q;
	logic [15:0]       sp_q, pc_q, pcw_q;
	logic              fault_q;
	logic [7:0]        op_q, imm_lo_q, imm_hi_q, md_lo_q, md_hi_q, rb_q;
	logic [15:0]       w2a_q;
	logic [7:0]        w2d_q;
	logic              ov_q;
	logic [7:0]        oa_q, of_q, ob_q, oc_q, od_q, oe_q, oh_q, ol_q, orb_q;
	logic [15:0]       osp_q, opc_q;
	logic              ofault_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wd, mem_rd;

	logic [15:0] hl, bc, de, imm16, md16, sp_inc, sp_dec, rd_addr;
	logic        out_load;

	alu_req_t    req;
	alu_rsp_t    rsp;
	logic [7:0]  ex_a, ex_b, ex_c, ex_d, ex_e, ex_h, ex_l;
	logic [3:0]  ex_f;
	logic [15:0] ex_sp, ex_pc;
	logic        w1_en, w2_en;
	logic [15:0] w1_addr, w2_addr;
	logic [7:0]  w1_data, w2_data;

	assign hl     = {h_q, l_q};
	assign bc     = {b_q, c_q};
	assign de     = {d_q, e_q};
	assign imm16  = {imm_hi_q, imm_lo_q};
	assign md16   = {md_hi_q, md_lo_q};
	assign sp_inc = sp_q + 16'd1;
	assign sp_dec = sp_q - 16'd1;

	assign in_ready = (state_q == S_IDLE);
	assign out_load = (state_q == S_DONE) && (!ov_q || out_ready);

	cis_ram #(
		.DEPTH(MEM_DEPTH),
		.WIDTH(8)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wd),
		.rdata(mem_rd)
	);

	cis_alu u_alu (
		.req(req),
		.rsp(rsp)
	);

	always_comb begin
		case (rd_kind(op_q))
			RK_HL:   rd_addr = hl;
			RK_DE:   rd_addr = de;
			RK_HIGH: rd_addr = {8'hFF, imm_lo_q};
			RK_ABS:  rd_addr = imm16;
			RK_POP:  rd_addr = sp_q;
			default: rd_addr = hl;
		endcase
	end

	always_comb begin
		req.op  = ALU_ADDW;
		req.a   = 16'd0;
		req.b   = 16'd0;
		req.cin = 1'b0;
		req.fin = f_q;
		ex_a = a_q; ex_b = b_q; ex_c = c_q; ex_d = d_q;
		ex_e = e_q; ex_h = h_q; ex_l = l_q; ex_f = f_q;
		ex_sp = sp_q;
		ex_pc = pcw_q;
		w1_en = 1'b0; w1_addr = hl; w1_data = a_q;
		w2_en = 1'b0; w2_addr = rsp.res; w2_data = 8'd0;
		case (op_q)
			8'h01: begin ex_b = imm_hi_q; ex_c = imm_lo_q; end
			8'h11: begin ex_d = imm_hi_q; ex_e = imm_lo_q; end
			8'h21: begin ex_h = imm_hi_q; ex_l = imm_lo_q; end
			8'h31: ex_sp = imm16;
			8'h03, 8'h0B: begin
				req.a = bc;
				req.b = (op_q == 8'h03) ? 16'h0001 : 16'hFFFF;
				{ex_b, ex_c} = rsp.res;
			end
			8'h13, 8'h1B: begin
				req.a = de;
				req.b = (op_q == 8'h13) ? 16'h0001 : 16'hFFFF;
				{ex_d, ex_e} = rsp.res;
			end
			8'h23: begin req.a = hl; req.b = 16'h0001; {ex_h, ex_l} = rsp.res; end
			8'h33: begin req.a = sp_q; req.b = 16'h0001; ex_sp = rsp.res; end
			8'h3B: begin req.a = sp_q; req.b = 16'hFFFF; ex_sp = rsp.res; end
			8'h22, 8'h32: begin
				w1_en = 1'b1;
				req.a = hl;
				req.b = (op_q == 8'h22) ? 16'h0001 : 16'hFFFF;
				{ex_h, ex_l} = rsp.res;
			end
			8'h2A: begin
				ex_a = md_lo_q;
				req.a = hl; req.b = 16'h0001;
				{ex_h, ex_l} = rsp.res;
			end
			8'h04, 8'h05: begin
				req.op = (op_q == 8'h04) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, b_q}; ex_b = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h0C, 8'h0D: begin
				req.op = (op_q == 8'h0C) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, c_q}; ex_c = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h14: begin
				req.op = ALU_INC8; req.a = {8'd0, d_q}; ex_d = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h1C, 8'h1D: begin
				req.op = (op_q == 8'h1C) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, e_q}; ex_e = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h24, 8'h25: begin
				req.op = (op_q == 8'h24) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, h_q}; ex_h = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h2C, 8'h2D: begin
				req.op = (op_q == 8'h2C) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, l_q}; ex_l = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h3C, 8'h3D: begin
				req.op = (op_q == 8'h3C) ? ALU_INC8 : ALU_DEC8;
				req.a = {8'd0, a_q}; ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h35: begin
				req.op = ALU_DEC8; req.a = {8'd0, md_lo_q};
				ex_f = rsp.f;
				w1_en = 1'b1; w1_data = rsp.res[7:0];
			end
			8'h06: ex_b = imm_lo_q;
			8'h0E: ex_c = imm_lo_q;
			8'h26: ex_h = imm_lo_q;
			8'h2E: ex_l = imm_lo_q;
			8'h3E: ex_a = imm_lo_q;
			8'h08: begin
				w1_en = 1'b1; w1_addr = imm16; w1_data = sp_q[7:0];
				req.a = imm16; req.b = 16'h0001;
				w2_en = 1'b1; w2_data = sp_q[15:8];
			end
			8'h12: begin w1_en = 1'b1; w1_addr = de; end
			8'h18, 8'h20, 8'h28, 8'h30, 8'h38: begin
				req.a = pcw_q;
				req.b = {{8{imm_lo_q[7]}}, imm_lo_q};
				if ((op_q == 8'h18) || (op_q == 8'h20 && !f_q[FZ]) ||
					(op_q == 8'h28 && f_q[FZ]) || (op_q == 8'h30 && !f_q[FC]) ||
					(op_q == 8'h38 && f_q[FC])) begin
					ex_pc = rsp.res;
				end
			end
			8'h1A, 8'h7E, 8'hF0, 8'hFA: ex_a = md_lo_q;
			8'h1F: begin
				req.op = ALU_RR; req.a = {8'd0, a_q};
				ex_a = rsp.res[7:0]; ex_f = {1'b0, rsp.f[2:0]};
			end
			8'h27: begin
				req.op = ALU_DAA; req.a = {8'd0, a_q};
				ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'h29, 8'h39: begin
				req.op = ALU_ADDHL; req.a = hl;
				req.b = (op_q == 8'h29) ? hl : sp_q;
				{ex_h, ex_l} = rsp.res; ex_f = rsp.f;
			end
			8'h44: ex_b = h_q;
			8'h46: ex_b = md_lo_q;
			8'h47: ex_b = a_q;
			8'h4E: ex_c = md_lo_q;
			8'h4F: ex_c = a_q;
			8'h56: ex_d = md_lo_q;
			8'h57: ex_d = a_q;
			8'h5D: ex_e = l_q;
			8'h5E: ex_e = md_lo_q;
			8'h5F: ex_e = a_q;
			8'h62: ex_h = d_q;
			8'h66: ex_h = md_lo_q;
			8'h67: ex_h = a_q;
			8'h6B: ex_l = e_q;
			8'h6E: ex_l = md_lo_q;
			8'h6F: ex_l = a_q;
			8'h70: begin w1_en = 1'b1; w1_data = b_q; end
			8'h71: begin w1_en = 1'b1; w1_data = c_q; end
			8'h72: begin w1_en = 1'b1; w1_data = d_q; end
			8'h73: begin w1_en = 1'b1; w1_data = e_q; end
			8'h77: w1_en = 1'b1;
			8'h78: ex_a = b_q;
			8'h79: ex_a = c_q;
			8'h7A: ex_a = d_q;
			8'h7B: ex_a = e_q;
			8'h7C: ex_a = h_q;
			8'h7D: ex_a = l_q;
			8'hA7, 8'hE6: begin
				req.op = ALU_AND; req.a = {8'd0, a_q};
				req.b = {8'd0, (op_q == 8'hA7) ? a_q : imm_lo_q};
				ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'hA9, 8'hAD, 8'hAE, 8'hAF, 8'hEE: begin
				req.op = ALU_XOR; req.a = {8'd0, a_q};
				case (op_q)
					8'hA9:   req.b = {8'd0, c_q};
					8'hAD:   req.b = {8'd0, l_q};
					8'hAE:   req.b = {8'd0, md_lo_q};
					8'hEE:   req.b = {8'd0, imm_lo_q};
					default: req.b = {8'd0, a_q};
				endcase
				ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'hB0, 8'hB1, 8'hB6, 8'hB7: begin
				req.op = ALU_OR; req.a = {8'd0, a_q};
				case (op_q)
					8'hB0:   req.b = {8'd0, b_q};
					8'hB1:   req.b = {8'd0, c_q};
					8'hB6:   req.b = {8'd0, md_lo_q};
					default: req.b = {8'd0, a_q};
				endcase
				ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hFE, 8'hD6: begin
				req.op = ALU_SUB8; req.a = {8'd0, a_q};
				case (op_q)
					8'hB8:   req.b = {8'd0, b_q};
					8'hB9:   req.b = {8'd0, c_q};
					8'hBA:   req.b = {8'd0, d_q};
					8'hBB:   req.b = {8'd0, e_q};
					default: req.b = {8'd0, imm_lo_q};
				endcase
				ex_f = rsp.f;
				if (op_q == 8'hD6) begin
					ex_a = rsp.res[7:0];
				end
			end
			8'hC6, 8'hCE: begin
				req.op = ALU_ADD8; req.a = {8'd0, a_q}; req.b = {8'd0, imm_lo_q};
				req.cin = (op_q == 8'hCE) ? f_q[FC] : 1'b0;
				ex_a = rsp.res[7:0]; ex_f = rsp.f;
			end
			8'hC1, 8'hD1, 8'hE1, 8'hF1: begin
				req.a = sp_q; req.b = 16'h0002; ex_sp = rsp.res;
				case (op_q)
					8'hC1:   {ex_b, ex_c} = md16;
					8'hD1:   {ex_d, ex_e} = md16;
					8'hE1:   {ex_h, ex_l} = md16;
					default: begin ex_a = md_hi_q; ex_f = md_lo_q[7:4]; end
				endcase
			end
			8'hC8, 8'hC9, 8'hD0: begin
				req.a = sp_q; req.b = 16'h0002;
				if ((op_q == 8'hC9) || (op_q == 8'hC8 && f_q[FZ]) ||
					(op_q == 8'hD0 && !f_q[FC])) begin
					ex_sp = rsp.res;
					ex_pc = md16;
				end
			end
			8'hC2: if (!f_q[FZ]) ex_pc = imm16;
			8'hC3: ex_pc = imm16;
			8'hC4, 8'hCD: begin
				req.a = sp_q; req.b = 16'hFFFE;
				if (op_q == 8'hCD || !f_q[FZ]) begin
					ex_pc = imm16;
					ex_sp = rsp.res;
					w1_en = 1'b1; w1_addr = sp_dec; w1_data = pcw_q[15:8];
					w2_en = 1'b1; w2_data = pcw_q[7:0];
				end
			end
			8'hC5, 8'hD5, 8'hE5, 8'hF5: begin
				req.a = sp_q; req.b = 16'hFFFE;
				ex_sp = rsp.res;
				w1_en = 1'b1; w1_addr = sp_dec;
				w2_en = 1'b1;
				case (op_q)
					8'hC5:   begin w1_data = b_q; w2_data = c_q; end
					8'hD5:   begin w1_data = d_q; w2_data = e_q; end
					8'hE5:   begin w1_data = h_q; w2_data = l_q; end
					default: begin w1_data = a_q; w2_data = {f_q, 4'h0}; end
				endcase
			end
			8'hCB: begin
				req.op = (imm_lo_q == 8'h38) ? ALU_SRL : ALU_RR;
				case (imm_lo_q)
					8'h38:   req.a = {8'd0, b_q};
					8'h19:   req.a = {8'd0, c_q};
					8'h1A:   req.a = {8'd0, d_q};
					default: req.a = {8'd0, e_q};
				endcase
				ex_f = rsp.f;
				case (imm_lo_q)
					8'h38:   ex_b = rsp.res[7:0];
					8'h19:   ex_c = rsp.res[7:0];
					8'h1A:   ex_d = rsp.res[7:0];
					default: ex_e = rsp.res[7:0];
				endcase
			end
			8'hE0: begin w1_en = 1'b1; w1_addr = {8'hFF, imm_lo_q}; end
			8'hEA: begin w1_en = 1'b1; w1_addr = imm16; end
			8'hE8, 8'hF8: begin
				req.op = ALU_SPE; req.a = sp_q; req.b = {8'd0, imm_lo_q};
				ex_f = rsp.f;
				if (op_q == 8'hE8) begin
					ex_sp = rsp.res;
				end else begin
					{ex_h, ex_l} = rsp.res;
				end
			end
			8'hE9: ex_pc = hl;
			8'hF9: ex_sp = hl;
			default: ex_pc = pcw_q;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = pcw_q[ADDR_W-1:0];
		mem_wd   = 8'd0;
		case (state_q)
			S_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				mem_wd   = (clr_q == MARK_ADDR[ADDR_W-1:0]) ? MARK_BYTE : 8'd0;
			end
			S_IDLE: begin
				if (command == CMD_WRITE) begin
					mem_we   = in_valid;
					mem_addr = address[ADDR_W-1:0];
					mem_wd   = write_byte;
				end else if (command == CMD_READ) begin
					mem_addr = address[ADDR_W-1:0];
				end else begin
					mem_addr = pc_q[ADDR_W-1:0];
				end
			end
			S_MEM: mem_addr = rd_addr[ADDR_W-1:0];
			S_RD1: mem_addr = sp_inc[ADDR_W-1:0];
			S_EXE: begin
				mem_we   = w1_en;
				mem_addr = w1_addr[ADDR_W-1:0];
				mem_wd   = w1_data;
			end
			S_WR2: begin
				mem_we   = 1'b1;
				mem_addr = w2a_q[ADDR_W-1:0];
				mem_wd   = w2d_q;
			end
			default: mem_addr = pcw_q[ADDR_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			a_q <= RST_A; b_q <= RST_B; c_q <= RST_C; d_q <= RST_D;
			e_q <= RST_E; h_q <= RST_H; l_q <= RST_L; f_q <= RST_F;
			sp_q    <= RST_SP;
			pc_q    <= RST_PC;
			pcw_q   <= RST_PC;
			fault_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (command == CMD_READ) begin
							state_q <= S_RDW;
						end else if (command == CMD_STEP && !fault_q) begin
							pcw_q   <= pc_q + 16'd1;
							state_q <= S_OP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RDW: state_q <= S_DONE;
				S_OP: begin
					if (!op_known(mem_rd)) begin
						fault_q <= 1'b1;
						state_q <= S_DONE;
					end else if (op_len(mem_rd) != 2'd0) begin
						pcw_q   <= pcw_q + 16'd1;
						state_q <= S_IMM1;
					end else begin
						state_q <= S_MEM;
					end
				end
				S_IMM1: begin
					if (op_q == 8'hCB && !cb_known(mem_rd)) begin
						fault_q <= 1'b1;
						state_q <= S_DONE;
					end else if (op_len(op_q) == 2'd2) begin
						pcw_q   <= pcw_q + 16'd1;
						state_q <= S_IMM2;
					end else begin
						state_q <= S_MEM;
					end
				end
				S_IMM2: state_q <= S_MEM;
				S_MEM: state_q <= (rd_kind(op_q) == RK_NONE) ? S_EXE : S_RD1;
				S_RD1: state_q <= (rd_kind(op_q) == RK_POP) ? S_RD2 : S_EXE;
				S_RD2: state_q <= S_EXE;
				S_EXE: begin
					a_q <= ex_a; b_q <= ex_b; c_q <= ex_c; d_q <= ex_d;
					e_q <= ex_e; h_q <= ex_h; l_q <= ex_l; f_q <= ex_f;
					sp_q    <= ex_sp;
					pc_q    <= ex_pc;
					state_q <= w2_en ? S_WR2 : S_DONE;
				end
				S_WR2: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			rb_q <= 8'd0;
		end
		if (state_q == S_RDW) begin
			rb_q <= mem_rd;
		end
		if (state_q == S_OP) begin
			op_q <= mem_rd;
		end
		if (state_q == S_IMM1) begin
			imm_lo_q <= mem_rd;
		end
		if (state_q == S_IMM2) begin
			imm_hi_q <= mem_rd;
		end
		if (state_q == S_RD1) begin
			md_lo_q <= mem_rd;
		end
		if (state_q == S_RD2) begin
			md_hi_q <= mem_rd;
		end
		if (state_q == S_EXE) begin
			w2a_q <= w2_addr;
			w2d_q <= w2_data;
		end
		if (out_load) begin
			oa_q <= a_q; of_q <= {f_q, 4'h0};
			ob_q <= b_q; oc_q <= c_q; od_q <= d_q; oe_q <= e_q;
			oh_q <= h_q; ol_q <= l_q;
			osp_q <= sp_q; opc_q <= pc_q;
			ofault_q <= fault_q;
			orb_q <= rb_q;
		end
	end

	assign out_valid    = ov_q;
	assign reg_a        = oa_q;
	assign flag_byte    = of_q;
	assign reg_b        = ob_q;
	assign reg_c        = oc_q;
	assign reg_d        = od_q;
	assign reg_e        = oe_q;
	assign reg_h        = oh_q;
	assign reg_l        = ol_q;
	assign stack_ptr    = osp_q;
	assign prog_counter = opc_q;
	assign fault        = ofault_q;
	assign read_byte    = orb_q;

	`ASSERT_NEXT(a_fault_sticky, fault_q, fault_q)
	`ASSERT_IMPL(a_fault_source, $rose(fault_q),
		($past(state_q) == S_OP) || ($past(state_q) == S_IMM1))
	`ASSERT_IMPL(a_pc_from_exe, !$stable(pc_q), $past(state_q) == S_EXE)
	`ASSERT_IMPL(a_wr2_after_exe, state_q == S_WR2, $past(state_q) == S_EXE)

endmodule
